FILE: src/msa_pkg.sv
// Shared constants, codes and control types of the mean and standard error accumulator.
package msa_pkg;

   // Sample, count and field widths (the fraction point does not enter the integer math)
   localparam int SAMPLE_BITS = 20;
   localparam int COUNT_BITS  = 24;

   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 20;
   localparam int MEAN_W     = 20;
   localparam int SE_W       = 19;
   localparam int CNT_OUT_W  = 24;
   localparam int STATUS_W   = 2;

   // Accumulator and shared divide / square root widths
   localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int SQSUM_W = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int DIV_W   = SQSUM_W;
   localparam int RAD_W   = DIV_W + (DIV_W % 2);
   localparam int RT_W    = RAD_W / 2;
   localparam int STEP_W  = $clog2(DIV_W);
   localparam int SE_MAX  = (2 ** SE_W) - 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REPORT = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_SATURATED = 2'd2
   } status_type;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_MEAN_LOAD = 3'd1,
      OP_DIV_STEP  = 3'd2,
      OP_SQUARE    = 3'd3,
      OP_VAR_LOAD  = 3'd4,
      OP_ROOT_LOAD = 3'd5,
      OP_ROOT_STEP = 3'd6,
      OP_OUT_LOAD  = 3'd7
   } dp_op_type;

   typedef struct packed {
      logic      acc_add;
      logic      acc_clear;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: src/msa_req_if.sv
// Request channel: command and sample beats into the accumulator.
interface msa_req_if;
   logic                                valid;
   logic                                ready;
   logic [msa_pkg::CMD_W-1:0]           cmd;
   logic signed [msa_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

FILE: src/msa_rsp_if.sv
// Response channel: report beats out of the accumulator.
interface msa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [msa_pkg::MEAN_W-1:0]    mean;
   logic [msa_pkg::SE_W-1:0]             std_error;
   logic [msa_pkg::CNT_OUT_W-1:0]        sample_count;
   logic [msa_pkg::STATUS_W-1:0]         status;

   modport source (output valid, output mean, output std_error, output sample_count,
                   output status, input ready);
   modport sink   (input valid, input mean, input std_error, input sample_count,
                   input status, output ready);
endinterface

FILE: src/msa_datapath.sv
// Accumulators, shared restoring divider, digit square root and response register.
module msa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  msa_pkg::ctrl_cmd_type               cmd,
   input  logic signed [msa_pkg::SAMPLE_W-1:0] sample,
   input  logic                                rsp_ready,
   output msa_pkg::dp_stat_type                stat,
   output logic                                rsp_valid,
   output logic signed [msa_pkg::MEAN_W-1:0]   rsp_mean,
   output logic [msa_pkg::SE_W-1:0]            rsp_std_error,
   output logic [msa_pkg::CNT_OUT_W-1:0]       rsp_sample_count,
   output logic [msa_pkg::STATUS_W-1:0]        rsp_status
);
   localparam int SB      = msa_pkg::SAMPLE_BITS;
   localparam int CB      = msa_pkg::COUNT_BITS;
   localparam int SUM_W   = msa_pkg::SUM_W;
   localparam int SQ_W    = msa_pkg::SQ_W;
   localparam int SQSUM_W = msa_pkg::SQSUM_W;
   localparam int DIV_W   = msa_pkg::DIV_W;
   localparam int RAD_W   = msa_pkg::RAD_W;
   localparam int RT_W    = msa_pkg::RT_W;
   localparam int MEAN_W  = msa_pkg::MEAN_W;
   localparam int SE_W    = msa_pkg::SE_W;
   localparam int CO_W    = msa_pkg::CNT_OUT_W;
   localparam logic [RT_W-1:0] SE_LIMIT = RT_W'(msa_pkg::SE_MAX);

   // Gatherer state
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQSUM_W-1:0]      sqsum_ff, sqsum_in;
   logic [CB-1:0]           count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic                    pend_ff, pend_in;
   logic signed [SB-1:0]    sadd_ff;
   logic [SQ_W-1:0]         sq_ff;

   // Report working registers
   logic                    neg_ff, neg_in;
   logic [CB-1:0]           rem_ff, rem_in;
   logic [DIV_W-1:0]        quo_ff, quo_in;
   logic signed [SB-1:0]    mean_ff, mean_in;
   logic [SQ_W-1:0]         msq_ff, msq_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [RT_W-1:0]         root_ff, root_in;
   logic [RT_W+1:0]         srem_ff, srem_in;

   // Response register
   logic                     out_full_ff, out_full_in;
   logic signed [MEAN_W-1:0] o_mean_ff, o_mean_in;
   logic [SE_W-1:0]          o_se_ff, o_se_in;
   logic [CO_W-1:0]          o_cnt_ff, o_cnt_in;
   logic [1:0]               o_stat_ff, o_stat_in;

   logic signed [SB-1:0] sample_s;
   logic [SB-1:0]        sample_mag;
   logic                 count_max;
   logic [SUM_W-1:0]     sum_mag;
   logic [SB-1:0]        mmag;
   logic [CB:0]          div_sh, div_diff;
   logic                 div_ge;
   logic [RT_W+3:0]      rt_sh, rt_trial, rt_diff;
   logic                 rt_ge;
   logic [DIV_W-1:0]     msq_wide;
   logic [SE_W-1:0]      se_val;

   assign sample_s   = sample[SB-1:0];
   assign sample_mag = sample_s[SB-1] ? SB'(-sample_s) : SB'(sample_s);
   assign count_max  = &count_ff;
   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mmag       = quo_ff[SB-1:0];
   assign msq_wide   = DIV_W'(msq_ff);

   // One restoring divide step: divisor is the sample count
   assign div_sh   = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge   = div_sh >= {1'b0, count_ff};
   assign div_diff = div_sh - {1'b0, count_ff};

   // One square root digit: two radicand bits in, one root bit out
   assign rt_sh    = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign rt_trial = {2'b00, root_ff, 2'b01};
   assign rt_ge    = rt_sh >= rt_trial;
   assign rt_diff  = rt_sh - rt_trial;

   assign se_val = (root_ff > SE_LIMIT) ? SE_W'(SE_LIMIT) : SE_W'(root_ff);

   // Accumulate side: squares are registered ahead of the sums
   always_comb begin
      sum_in   = sum_ff;
      sqsum_in = sqsum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pend_in  = 1'b0;
      if (cmd.acc_clear) begin
         sum_in   = '0;
         sqsum_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (pend_ff) begin
            sum_in   = sum_ff + SUM_W'(sadd_ff);
            sqsum_in = sqsum_ff + SQSUM_W'(sq_ff);
         end
         if (cmd.acc_add) begin
            if (count_max) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               pend_in  = 1'b1;
            end
         end
      end
   end

   // Report side operations
   always_comb begin
      neg_in    = neg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mean_in   = mean_ff;
      msq_in    = msq_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      o_mean_in = o_mean_ff;
      o_se_in   = o_se_ff;
      o_cnt_in  = o_cnt_ff;
      o_stat_in = o_stat_ff;
      unique case (cmd.op)
         msa_pkg::OP_NONE: begin
         end
         msa_pkg::OP_MEAN_LOAD: begin
            neg_in = sum_ff[SUM_W-1];
            rem_in = '0;
            quo_in = DIV_W'(sum_mag);
         end
         msa_pkg::OP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[CB-1:0] : div_sh[CB-1:0];
            quo_in = {quo_ff[DIV_W-2:0], div_ge};
         end
         msa_pkg::OP_SQUARE: begin
            mean_in = neg_ff ? SB'(-mmag) : SB'(mmag);
            msq_in  = mmag * mmag;
            rem_in  = '0;
            quo_in  = DIV_W'(sqsum_ff);
         end
         msa_pkg::OP_VAR_LOAD: begin
            rem_in = '0;
            quo_in = (quo_ff > msq_wide) ? (quo_ff - msq_wide) : '0;
         end
         msa_pkg::OP_ROOT_LOAD: begin
            rad_in  = RAD_W'(quo_ff);
            root_in = '0;
            srem_in = '0;
         end
         msa_pkg::OP_ROOT_STEP: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            root_in = {root_ff[RT_W-2:0], rt_ge};
            srem_in = rt_ge ? rt_diff[RT_W+1:0] : rt_sh[RT_W+1:0];
         end
         msa_pkg::OP_OUT_LOAD: begin
            if (count_ff == '0) begin
               o_mean_in = '0;
               o_se_in   = '0;
               o_cnt_in  = '0;
               o_stat_in = msa_pkg::STAT_EMPTY;
            end else begin
               o_mean_in = MEAN_W'(mean_ff);
               o_se_in   = se_val;
               o_cnt_in  = CO_W'(count_ff);
               o_stat_in = ovf_ff ? msa_pkg::STAT_SATURATED : msa_pkg::STAT_OK;
            end
         end
         default: begin
         end
      endcase
   end

   assign out_full_in = (cmd.op == msa_pkg::OP_OUT_LOAD) || (out_full_ff && !rsp_ready);

   // Control and gatherer state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         sqsum_ff    <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         pend_ff     <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         sqsum_ff    <= sqsum_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         pend_ff     <= pend_in;
         out_full_ff <= out_full_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.acc_add) begin
         sadd_ff <= sample_s;
         sq_ff   <= sample_mag * sample_mag;
      end
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mean_ff   <= mean_in;
      msq_ff    <= msq_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      o_mean_ff <= o_mean_in;
      o_se_ff   <= o_se_in;
      o_cnt_ff  <= o_cnt_in;
      o_stat_ff <= o_stat_in;
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.out_free   = !out_full_ff || rsp_ready;

   assign rsp_valid        = out_full_ff;
   assign rsp_mean         = o_mean_ff;
   assign rsp_std_error    = o_se_ff;
   assign rsp_sample_count = o_cnt_ff;
   assign rsp_status       = o_stat_ff;

endmodule

FILE: src/msa_ctrl.sv
// Report sequencer: steps the datapath through mean, mean square, variance and root.
module msa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [msa_pkg::CMD_W-1:0] req_cmd,
   output logic                      req_ready,
   input  msa_pkg::dp_stat_type      stat,
   output msa_pkg::ctrl_cmd_type     cmd
);
   localparam int STEP_W = msa_pkg::STEP_W;
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(msa_pkg::DIV_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(msa_pkg::RT_W - 1);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_MEAN_LOAD = 10'b00_0000_0010,
      ST_MEAN_DIV  = 10'b00_0000_0100,
      ST_SQUARE    = 10'b00_0000_1000,
      ST_MS_DIV    = 10'b00_0001_0000,
      ST_VAR_LOAD  = 10'b00_0010_0000,
      ST_VAR_DIV   = 10'b00_0100_0000,
      ST_ROOT_LOAD = 10'b00_1000_0000,
      ST_ROOT      = 10'b01_0000_0000,
      ST_FINISH    = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               accept;
   msa_pkg::dp_op_type op_sel;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Add and clear beats go straight to the gatherer
   assign cmd.acc_add   = accept && (req_cmd == msa_pkg::CMD_ADD);
   assign cmd.acc_clear = accept && (req_cmd == msa_pkg::CMD_CLEAR);
   assign cmd.op        = op_sel;

   // Next state, step count and datapath operation
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      op_sel   = msa_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == msa_pkg::CMD_REPORT)) begin
               state_in = ST_MEAN_LOAD;
            end
         end
         ST_MEAN_LOAD: begin
            if (stat.count_zero) begin
               state_in = ST_FINISH;
            end else begin
               op_sel   = msa_pkg::OP_MEAN_LOAD;
               step_in  = DIV_LAST;
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            op_sel  = msa_pkg::OP_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            op_sel   = msa_pkg::OP_SQUARE;
            step_in  = DIV_LAST;
            state_in = ST_MS_DIV;
         end
         ST_MS_DIV: begin
            op_sel  = msa_pkg::OP_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_VAR_LOAD;
            end
         end
         ST_VAR_LOAD: begin
            op_sel   = msa_pkg::OP_VAR_LOAD;
            step_in  = DIV_LAST;
            state_in = ST_VAR_DIV;
         end
         ST_VAR_DIV: begin
            op_sel  = msa_pkg::OP_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_ROOT_LOAD;
            end
         end
         ST_ROOT_LOAD: begin
            op_sel   = msa_pkg::OP_ROOT_LOAD;
            step_in  = ROOT_LAST;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            op_sel  = msa_pkg::OP_ROOT_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (stat.out_free) begin
               op_sel   = msa_pkg::OP_OUT_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: src/mean_stderr_accumulator.sv
// Top level of the running mean and standard error accumulator.
// Add and clear beats are taken one per cycle, back to back, while the block is idle: the
// sample square is registered and then folded into the sums. A report beat makes the
// block busy (req.ready low) until the result sits in the response register; the steps
// are the shared one-bit-per-cycle divider (mean, mean square, variance over n) and the
// two-bit-per-cycle square root. With no samples a report skips them and returns zeros
// and empty status. The response register lets new beats be accepted while a report
// waits to be taken. The mean is truncated toward zero, a negative variance reads as zero,
// the standard error is saturated to 19 bits, and once the count saturates further
// samples are dropped and reports carry the saturated status until a clear. Reset clears
// all sums and the count.
module mean_stderr_accumulator (
   input  logic      clock,
   input  logic      reset,
   msa_req_if.sink   req,
   msa_rsp_if.source rsp
);
   msa_pkg::ctrl_cmd_type cmd;
   msa_pkg::dp_stat_type  stat;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sample           (req.sample),
      .rsp_ready        (rsp.ready),
      .stat             (stat),
      .rsp_valid        (rsp.valid),
      .rsp_mean         (rsp.mean),
      .rsp_std_error    (rsp.std_error),
      .rsp_sample_count (rsp.sample_count),
      .rsp_status       (rsp.status)
   );

endmodule

FILE: src/msa_checker.sv
// Port-level checks of the accumulator, bound to the top level.
module msa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [msa_pkg::CMD_W-1:0]           req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [msa_pkg::MEAN_W-1:0]   rsp_mean,
   input logic [msa_pkg::SE_W-1:0]            rsp_std_error,
   input logic [msa_pkg::CNT_OUT_W-1:0]       rsp_sample_count,
   input logic [msa_pkg::STATUS_W-1:0]        rsp_status
);
   // No response beat right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   // A report beat makes the block busy
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == msa_pkg::CMD_REPORT) |=> !req_ready)
      else $error("ready after report beat");

   // Add, clear and unused beats leave the block ready
   a_add_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != msa_pkg::CMD_REPORT) |=> req_ready)
      else $error("ready dropped after non-report beat");

   // Empty status exactly when the count is zero, with zero results
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_sample_count == '0) == (rsp_status == msa_pkg::STAT_EMPTY))
         && ((rsp_status != msa_pkg::STAT_EMPTY)
            || ((rsp_mean == '0) && (rsp_std_error == '0))))
      else $error("empty status inconsistent with results");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean) && $stable(rsp_status))
      else $error("stalled response beat changed");

endmodule

bind mean_stderr_accumulator msa_checker u_msa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_cmd          (req.cmd),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_mean         (rsp.mean),
   .rsp_std_error    (rsp.std_error),
   .rsp_sample_count (rsp.sample_count),
   .rsp_status       (rsp.status)
);
